>>> hw/rtl/zlib_stored_block_encoder_assert.svh
// Assertion macros shared by the zlib stored block encoder RTL.
`ifndef ZLIB_STORED_BLOCK_ENCODER_ASSERT_SVH
`define ZLIB_STORED_BLOCK_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ZSBE_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define ZSBE_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZSBE_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)
`define ZSBE_ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif
`endif

>>> hw/rtl/zsbe_pkg.sv
// Types and constants shared by the zlib stored block encoder modules.
`default_nettype none
package zsbe_pkg;

  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        zlib_hdr;    // stream header goes first
    logic        blk_hdr;     // a stored block header goes first
    logic        blk_final;   // final-block flag of that header
    logic [15:0] blk_len;     // LEN of that header
    logic        trailer;     // checksum follows the data byte
    logic [31:0] adler;       // {high, low} after this byte
  } entry_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_CMF,
    ST_FLG,
    ST_BFINAL,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_NLEN_LO,
    ST_NLEN_HI,
    ST_DATA,
    ST_ADL3,
    ST_ADL2,
    ST_ADL1,
    ST_ADL0
  } step_t;

endpackage
`default_nettype wire

>>> hw/rtl/zlib_stored_block_encoder.sv
// Top level of the zlib stored block encoder: register port, front, queue and back.
// Usage: raw bytes enter on data_byte with in_valid/in_ready; each accepted item
// produces one to twelve bytes of a zlib stream made of stored deflate blocks on
// out_byte with out_valid/out_ready. last_of_run marks the final byte caused by an
// item and end_of_stream marks the last Adler-32 trailer byte of a stream.
// The stream length is the total_length register at byte address 0 of the APB
// port (reset 1, a zero acts as 1); write it only while the block is idle.
// The front accepts an item in the same cycle it is offered whenever the
// four-entry queue has room, classifying it and updating Adler-32 right away.
// The back emits one byte per cycle while the receiver is ready, from the queue
// head into an output register; an item's first byte passes through the queue and
// then that register. Inside a block the rate, set by the output serializer, is
// one item per cycle when nothing stalls; the stream header, each block header and
// the checksum trailer add their bytes. On a receiver stall the output register
// holds its byte, the queue fills, and then in_ready drops until space frees up.
// Reset clears the framing state, the checksum, the queue and the output stage.
`default_nettype none
`include "zlib_stored_block_encoder_assert.svh"
module zlib_stored_block_encoder #(
  parameter int MAX_BLOCK = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_stream
);

  logic [31:0] total_length;
  logic        q_push, q_pop, q_full, q_empty;
  zsbe_pkg::entry_t front_entry, head_entry;

  // Register port: a single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? total_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= 32'd1;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      total_length <= pwdata;
    end
  end

  zsbe_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .total_length (total_length),
    .q_full       (q_full),
    .push         (q_push),
    .entry        (front_entry)
  );

  zsbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (front_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  zsbe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head_entry),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_stream (end_of_stream)
  );

  // An accepted item must be waiting in the queue on the next cycle.
  `ZSBE_ASSERT_NEXT(a_push_lands, clk, rst, in_valid && in_ready, !q_empty, "accepted item missing from queue")
  // The back never retires an item from an empty queue.
  `ZSBE_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, !q_empty, "pop from empty queue")
  // The trailer's last byte always closes the run of its item.
  `ZSBE_ASSERT_IMPLIES(a_eos_closes, clk, rst, out_valid && end_of_stream, last_of_run, "end of stream not last of run")

endmodule
`default_nettype wire

>>> hw/rtl/zsbe_front.sv
// Front end: accepts raw bytes, tracks framing and Adler-32, classifies each item.
`default_nettype none
module zsbe_front #(
  parameter int MAX_BLOCK = 65535
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       data_byte,
  input  wire logic [31:0]      total_length,
  input  wire logic             q_full,
  output logic                  push,
  output zsbe_pkg::entry_t      entry
);

  localparam logic [15:0] MaxBlk = MAX_BLOCK[15:0];

  logic        header_sent, header_sent_next;
  logic [31:0] bytes_done, bytes_done_next;
  logic [15:0] block_left, block_left_next;
  logic [15:0] adler_low, adler_low_next;
  logic [15:0] adler_high, adler_high_next;

  logic [31:0] total;
  logic        blk_start;
  logic [31:0] remaining;
  logic        rem_fits;
  logic [15:0] len;
  logic [31:0] done_count;
  logic        stream_done;
  logic [16:0] a_sum, b_sum;
  logic [15:0] a_mod, b_mod;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    total      = (total_length == 32'd0) ? 32'd1 : total_length;
    blk_start  = (block_left == 16'd0);
    remaining  = (total > bytes_done) ? (total - bytes_done) : 32'd1;
    rem_fits   = (remaining <= {16'd0, MaxBlk});
    len        = rem_fits ? remaining[15:0] : MaxBlk;
    done_count = bytes_done + 32'd1;
    stream_done = (done_count >= total);

    a_sum = {1'b0, adler_low} + {9'd0, data_byte};
    a_mod = (a_sum >= zsbe_pkg::ADLER_MOD) ? 16'(a_sum - zsbe_pkg::ADLER_MOD) : a_sum[15:0];
    b_sum = {1'b0, adler_high} + {1'b0, a_mod};
    b_mod = (b_sum >= zsbe_pkg::ADLER_MOD) ? 16'(b_sum - zsbe_pkg::ADLER_MOD) : b_sum[15:0];

    entry.data      = data_byte;
    entry.zlib_hdr  = !header_sent;
    entry.blk_hdr   = blk_start;
    entry.blk_final = rem_fits;
    entry.blk_len   = len;
    entry.trailer   = stream_done;
    entry.adler     = {b_mod, a_mod};

    if (stream_done) begin
      header_sent_next = 1'b0;
      bytes_done_next  = 32'd0;
      block_left_next  = 16'd0;
      adler_low_next   = 16'd1;
      adler_high_next  = 16'd0;
    end else begin
      header_sent_next = 1'b1;
      bytes_done_next  = done_count;
      block_left_next  = (blk_start ? len : block_left) - 16'd1;
      adler_low_next   = a_mod;
      adler_high_next  = b_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_sent <= 1'b0;
      bytes_done  <= 32'd0;
      block_left  <= 16'd0;
      adler_low   <= 16'd1;
      adler_high  <= 16'd0;
    end else if (push) begin
      header_sent <= header_sent_next;
      bytes_done  <= bytes_done_next;
      block_left  <= block_left_next;
      adler_low   <= adler_low_next;
      adler_high  <= adler_high_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/zsbe_queue.sv
// Small FIFO of classified items between the front and the back.
`default_nettype none
module zsbe_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire zsbe_pkg::entry_t  wr_entry,
  input  wire logic              pop,
  output zsbe_pkg::entry_t       rd_entry,
  output logic                   full,
  output logic                   empty
);

  zsbe_pkg::entry_t mem [zsbe_pkg::QUEUE_DEPTH];

  logic [zsbe_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [zsbe_pkg::QUEUE_AW:0]   count;
  logic                          do_push, do_pop;

  assign full     = (count == (zsbe_pkg::QUEUE_AW + 1)'(zsbe_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/zsbe_back.sv
// Back end: expands each queued item into its output bytes, one per cycle while not stalled.
`default_nettype none
module zsbe_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire zsbe_pkg::entry_t  head,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   last_of_run,
  output logic                   end_of_stream
);

  zsbe_pkg::step_t step, step_next, cur;
  logic            advance, fire, is_last;
  logic [7:0]      byte_sel;
  logic [15:0]     nlen;

  assign advance = !out_valid || out_ready;
  assign fire    = advance && !q_empty;
  assign pop     = fire && is_last;
  assign nlen    = ~head.blk_len;

  // Next-step logic.
  always_comb begin
    if (step == zsbe_pkg::ST_START) begin
      if (head.zlib_hdr) begin
        cur = zsbe_pkg::ST_CMF;
      end else if (head.blk_hdr) begin
        cur = zsbe_pkg::ST_BFINAL;
      end else begin
        cur = zsbe_pkg::ST_DATA;
      end
    end else begin
      cur = step;
    end
    is_last = 1'b0;
    unique case (cur)
      zsbe_pkg::ST_CMF:     step_next = zsbe_pkg::ST_FLG;
      zsbe_pkg::ST_FLG:     step_next = head.blk_hdr ? zsbe_pkg::ST_BFINAL : zsbe_pkg::ST_DATA;
      zsbe_pkg::ST_BFINAL:  step_next = zsbe_pkg::ST_LEN_LO;
      zsbe_pkg::ST_LEN_LO:  step_next = zsbe_pkg::ST_LEN_HI;
      zsbe_pkg::ST_LEN_HI:  step_next = zsbe_pkg::ST_NLEN_LO;
      zsbe_pkg::ST_NLEN_LO: step_next = zsbe_pkg::ST_NLEN_HI;
      zsbe_pkg::ST_NLEN_HI: step_next = zsbe_pkg::ST_DATA;
      zsbe_pkg::ST_DATA: begin
        if (head.trailer) begin
          step_next = zsbe_pkg::ST_ADL3;
        end else begin
          step_next = zsbe_pkg::ST_START;
          is_last   = 1'b1;
        end
      end
      zsbe_pkg::ST_ADL3:    step_next = zsbe_pkg::ST_ADL2;
      zsbe_pkg::ST_ADL2:    step_next = zsbe_pkg::ST_ADL1;
      zsbe_pkg::ST_ADL1:    step_next = zsbe_pkg::ST_ADL0;
      zsbe_pkg::ST_ADL0: begin
        step_next = zsbe_pkg::ST_START;
        is_last   = 1'b1;
      end
      default:              step_next = zsbe_pkg::ST_START;
    endcase
  end

  // Output byte selection.
  always_comb begin
    unique case (cur)
      zsbe_pkg::ST_CMF:     byte_sel = zsbe_pkg::ZLIB_CMF;
      zsbe_pkg::ST_FLG:     byte_sel = zsbe_pkg::ZLIB_FLG;
      zsbe_pkg::ST_BFINAL:  byte_sel = {7'd0, head.blk_final};
      zsbe_pkg::ST_LEN_LO:  byte_sel = head.blk_len[7:0];
      zsbe_pkg::ST_LEN_HI:  byte_sel = head.blk_len[15:8];
      zsbe_pkg::ST_NLEN_LO: byte_sel = nlen[7:0];
      zsbe_pkg::ST_NLEN_HI: byte_sel = nlen[15:8];
      zsbe_pkg::ST_DATA:    byte_sel = head.data;
      zsbe_pkg::ST_ADL3:    byte_sel = head.adler[31:24];
      zsbe_pkg::ST_ADL2:    byte_sel = head.adler[23:16];
      zsbe_pkg::ST_ADL1:    byte_sel = head.adler[15:8];
      zsbe_pkg::ST_ADL0:    byte_sel = head.adler[7:0];
      default:              byte_sel = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= zsbe_pkg::ST_START;
      out_valid <= 1'b0;
    end else if (fire) begin
      step      <= step_next;
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte      <= byte_sel;
      last_of_run   <= is_last;
      end_of_stream <= (cur == zsbe_pkg::ST_ADL0);
    end
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the zlib stored block encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Largest LEN of one stored deflate block.
  localparam int BLOCK_LIMIT = 65535;

  // Register map of the configuration port.
  localparam logic [2:0] REG_TOTAL_LENGTH = 3'd0;

  // Length of the long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 100;

  // One byte of the zlib stream together with its two flags.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       eos;
  } zbyte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        end_of_stream;

  zlib_stored_block_encoder #(
    .MAX_BLOCK(BLOCK_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .last_of_run(last_of_run),
    .end_of_stream(end_of_stream)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Raw bytes waiting to be offered, and stream bytes waiting to come out.
  logic [7:0] raw_pending[$];
  zbyte_t     zlib_bytes_due[$];

  // Idle percentages of the two sides, changed by the stimulus as it goes.
  int gap_pct = 26;
  int stall_pct = 75;

  // The stimulus asks for a hold-off by bumping hold_asked; the receiver
  // process serves it and counts the cycles itself.
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;

  // Set at each rising edge when the offered item was taken.
  logic in_fire = 1'b0;

  // Run statistics.
  int mismatches = 0;
  int items_taken = 0;
  int bytes_checked = 0;
  int streams_closed = 0;
  int blocks_opened = 0;
  int low_sum_wraps = 0;
  int reg_writes = 0;

  // Shadow of the length register and of the framing and checksum state.
  logic [31:0] length_shadow;
  logic        zlib_hdr_out;
  logic [31:0] raw_count;
  logic [15:0] block_room;
  logic [15:0] adler_lo_sum;
  logic [15:0] adler_hi_sum;

  task automatic clear_stream();
    zlib_hdr_out = 1'b0;
    raw_count = '0;
    block_room = '0;
    adler_lo_sum = 16'd1;
    adler_hi_sum = '0;
  endtask

  // Works out every stream byte that one raw byte causes and queues them in
  // order. The last one carries last_of_run; the final checksum byte of a
  // stream also carries end_of_stream.
  task automatic wrap_raw_byte(input logic [7:0] raw);
    logic [7:0]  run[$];
    logic [31:0] goal;
    logic [31:0] remaining;
    logic [31:0] blen;
    logic [16:0] lo;
    logic [16:0] hi;
    logic        closes;
    zbyte_t      zb;
    // A zero length acts as a single byte.
    goal = (length_shadow == 0) ? 32'd1 : length_shadow;
    closes = 1'b0;
    if (!zlib_hdr_out) begin
      run.insert(run.size(), zsbe_pkg::ZLIB_CMF);
      run.insert(run.size(), zsbe_pkg::ZLIB_FLG);
      zlib_hdr_out = 1'b1;
    end
    // A new stored block opens here. If the length was lowered under the
    // count already taken, the block claims one byte and is marked final.
    if (block_room == 0) begin
      remaining = (goal > raw_count) ? goal - raw_count : 32'd1;
      blen = (remaining < 32'(BLOCK_LIMIT)) ? remaining : 32'(BLOCK_LIMIT);
      run.insert(run.size(), {7'd0, blen == remaining});
      run.insert(run.size(), blen[7:0]);
      run.insert(run.size(), blen[15:8]);
      run.insert(run.size(), ~blen[7:0]);
      run.insert(run.size(), ~blen[15:8]);
      block_room = blen[15:0];
      blocks_opened++;
    end
    run.insert(run.size(), raw);
    // Both sums stay below the modulus by one conditional subtraction each.
    lo = {1'b0, adler_lo_sum} + {9'd0, raw};
    if (lo >= zsbe_pkg::ADLER_MOD) begin
      lo = lo - zsbe_pkg::ADLER_MOD;
      low_sum_wraps++;
    end
    hi = {1'b0, adler_hi_sum} + lo;
    if (hi >= zsbe_pkg::ADLER_MOD) hi = hi - zsbe_pkg::ADLER_MOD;
    adler_lo_sum = lo[15:0];
    adler_hi_sum = hi[15:0];
    raw_count = raw_count + 32'd1;
    block_room = block_room - 16'd1;
    // The stream closes once the count reaches the length, even in the
    // middle of a block; the checksum then follows big-endian.
    if (raw_count >= goal) begin
      run.insert(run.size(), hi[15:8]);
      run.insert(run.size(), hi[7:0]);
      run.insert(run.size(), lo[15:8]);
      run.insert(run.size(), lo[7:0]);
      closes = 1'b1;
      streams_closed++;
      clear_stream();
    end
    foreach (run[k]) begin
      zb.value = run[k];
      zb.last = (k == run.size() - 1);
      zb.eos = closes && zb.last;
      zlib_bytes_due.insert(zlib_bytes_due.size(), zb);
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 10) $display("%0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  // Monitor: samples both channels and the register port at the rising edge.
  // Prediction runs before the output check, though an item's first byte can
  // never come out on the edge that takes the item.
  always @(posedge clk) begin
    zbyte_t want;
    if (rst) begin
      length_shadow = 32'd1;
      clear_stream();
      zlib_bytes_due.delete();
      in_fire <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TOTAL_LENGTH)
        length_shadow = pwdata;
      if (in_valid && in_ready) begin
        wrap_raw_byte(data_byte);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (zlib_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b eos %0b",
                                    out_byte, last_of_run, end_of_stream));
        end else begin
          want = zlib_bytes_due.pop_front();
          if (out_byte !== want.value || last_of_run !== want.last ||
              end_of_stream !== want.eos)
            report_mismatch($sformatf(
              "byte %0d: expected %02h last %0b eos %0b, got %02h last %0b eos %0b",
              bytes_checked, want.value, want.last, want.eos,
              out_byte, last_of_run, end_of_stream));
        end
        bytes_checked++;
      end
      in_fire <= in_valid && in_ready;
    end
  end

  // Driver: offers the next raw byte at the falling edge once the previous
  // item is gone, idling at random. A held item keeps its byte until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (raw_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_valid <= 1'b1;
        data_byte <= raw_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so that the
  // internal queue fills and the input side has to stall.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_given <= hold_given + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Register write: a setup cycle, then the access cycle held until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  task automatic queue_byte(input logic [7:0] value);
    raw_pending.insert(raw_pending.size(), value);
  endtask

  // Returns once every queued byte was taken and every stream byte arrived.
  // Each item causes at least one result, so nothing can still be in flight.
  // The check runs at the rising edge, where the driver's last change has
  // already settled.
  task automatic wait_drained();
    do @(posedge clk);
    while (raw_pending.size() != 0 || in_valid || zlib_bytes_due.size() != 0);
  endtask

  task automatic queue_random(input int count, input int lo, input int hi);
    repeat (count) queue_byte(8'($urandom_range(hi, lo)));
  endtask

  // Stimulus: a directed part, then random streams under three idle modes.
  initial begin
    logic [31:0] reg_len;
    int sent;
    int cut;
    int left;
    int runs;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset length of one: a single byte makes the whole twelve-byte stream.
    queue_byte(8'h00);
    wait_drained();
    // A zero length behaves like one.
    write_reg(REG_TOTAL_LENGTH, 32'd0);
    queue_byte(8'hFF);
    wait_drained();
    // Length raised while a stream is open: the first block ends without
    // closing the stream. Then the length drops under the count already
    // taken, so the next block gets one byte and the final flag.
    write_reg(REG_TOTAL_LENGTH, 32'd3);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    wait_drained();
    write_reg(REG_TOTAL_LENGTH, 32'd5);
    queue_byte(8'h55);
    wait_drained();
    write_reg(REG_TOTAL_LENGTH, 32'd2);
    queue_byte(8'hAA);
    wait_drained();
    // Largest length: the first block takes the full LEN and is not final.
    // Lowering the length to one afterwards closes the stream in the middle
    // of that block.
    write_reg(REG_TOTAL_LENGTH, 32'hFFFF_FFFF);
    repeat (15) queue_byte(8'hFF);
    wait_drained();
    write_reg(REG_TOTAL_LENGTH, 32'd1);
    queue_byte(8'h01);
    wait_drained();

    // Random streams: first a busy sender against a slow receiver, then
    // the other way round. Most streams are well formed and come in short
    // trains of equal length; about one in five has its length changed
    // while it is open.
    for (int mode = 0; mode < 2; mode++) begin
      gap_pct = (mode == 0) ? 26 : 75;
      stall_pct = (mode == 0) ? 75 : 26;
      sent = 0;
      while (sent < 60) begin
        if ($urandom_range(4) == 0) begin
          reg_len = $urandom_range(1) ? $urandom() : 32'($urandom_range(40, 3));
          if (reg_len < 3) reg_len = 3;
          write_reg(REG_TOTAL_LENGTH, reg_len);
          cut = $urandom_range((reg_len > 21) ? 20 : int'(reg_len) - 1, 1);
          queue_random(cut, 0, 255);
          wait_drained();
          reg_len = $urandom_range(45, 0);
          write_reg(REG_TOTAL_LENGTH, reg_len);
          left = (reg_len > cut) ? int'(reg_len) - cut : 1;
          queue_random(left, 0, 255);
          sent += cut + left;
        end else begin
          reg_len = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(40, 2);
          write_reg(REG_TOTAL_LENGTH, reg_len);
          left = (reg_len == 0) ? 1 : int'(reg_len);
          runs = $urandom_range(3, 1);
          repeat (runs) queue_random(left, 0, 255);
          sent += runs * left;
        end
        wait_drained();
      end
    end

    // No idling: one long stream of high byte values, long enough that the low
    // checksum sum most likely passes the modulus. The receiver holds off at the
    // start while the sender keeps offering, so the block backs up.
    gap_pct = 0;
    stall_pct = 0;
    write_reg(REG_TOTAL_LENGTH, 32'd270);
    hold_asked++;
    queue_random(270, 240, 255);
    wait_drained();

    // Keep the clock running so that a stray extra byte would be seen.
    repeat (20) @(negedge clk);
    $display("Run covered %0d raw bytes in %0d streams and %0d stored blocks,",
             items_taken, streams_closed, blocks_opened);
    $display("%0d length writes; checked %0d stream bytes; low sum wrapped %0d times.",
             reg_writes, bytes_checked, low_sum_wraps);
    if (mismatches == 0 && zlib_bytes_due.size() == 0) begin
      $display("zlib_stored_block_encoder regression: pass");
    end else begin
      $display("zlib_stored_block_encoder regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d stream bytes still due.", zlib_bytes_due.size());
    $display("zlib_stored_block_encoder regression: fail");
    $finish;
  end

endmodule
